### hw/rtl/mchw_pkg.sv
// shared constants, types and codes of the heartbeat watchdog
`default_nettype none
package mchw_pkg;

    // table geometry
    localparam int CHANNELS = 32;
    localparam int CH_W     = 6;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WORD_W   = 32;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [CH_W-1:0]   t_chan;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [1:0]        t_action;
    typedef logic [2:0]        t_status;

    // action codes
    localparam t_action ACT_REG  = 2'd0;
    localparam t_action ACT_BEAT = 2'd1;
    localparam t_action ACT_SCAN = 2'd2;

    // status codes
    localparam t_status ST_REGISTERED  = 3'd0;
    localparam t_status ST_BEAT        = 3'd1;
    localparam t_status ST_BAD_CHANNEL = 3'd2;
    localparam t_status ST_FULL        = 3'd3;
    localparam t_status ST_STALE       = 3'd4;
    localparam t_status ST_DONE        = 3'd5;

    // timeout after reset
    localparam t_word TIMEOUT_RST = 32'd10;

endpackage
`default_nettype wire

### hw/rtl/mchw_ram.sv
// generic single write port ram with registered read
`default_nettype none
module mchw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hw/rtl/mchw_stale_cmp.sv
// shared staleness unit: signed gap and compare against the timeout
`default_nettype none
module mchw_stale_cmp (
    input  wire logic          i_stamp_vld,
    input  wire mchw_pkg::t_word i_stamp,
    input  wire mchw_pkg::t_word i_now,
    input  wire mchw_pkg::t_word i_timeout,
    output logic               o_stale
);
    import mchw_pkg::*;

    t_word gap;

    // gap wraps mod 2^32; a negative gap or a zero stamp is never stale
    always_comb begin
        gap     = i_now - i_stamp;
        o_stale = i_stamp_vld && (i_stamp != '0) && !gap[WORD_W-1] && (gap > i_timeout);
    end

endmodule
`default_nettype wire

### hw/rtl/multi_channel_heartbeat_watchdog_unit.sv
// top level of the multi-channel heartbeat watchdog
`default_nettype none
// Heartbeat watchdog over a table of CHANNELS time stamps. A register word hands
// out the next channel number (or reports the table full), a beat word stores
// its time stamp for a channel, and a scan word reports every registered channel
// whose stamp is nonzero and more than the timeout (signed gap) behind the given
// time, then a done word with last set. Register and beat words need no further
// state, so one can be accepted every cycle while the output register drains.
// A scan goes through a ram read state, then a compare state, per registered
// channel and a done state for the done word before the next word is taken
// (done at once with no channel registered); output stalls can hold it further.
// This order is set by the one read port of the stamp ram and the shared compare
// unit; no input is accepted while a scan runs. The table needs no clearing after
// reset: per-entry valid bits make an unwritten entry never stale.
module multi_channel_heartbeat_watchdog_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire mchw_pkg::t_word    i_cfg_data,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire mchw_pkg::t_action  i_action,
    input  wire mchw_pkg::t_chan    i_channel,
    input  wire mchw_pkg::t_word    i_now,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output mchw_pkg::t_status       o_status,
    output mchw_pkg::t_chan         o_channel_res,
    output mchw_pkg::t_word         o_last_beat,
    output logic                    o_last
);
    import mchw_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CHK  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]          r_state, n_state;
    t_idx                r_idx, n_idx;
    t_word               r_now, n_now;
    t_chan               r_count, n_count;
    t_word               r_timeout;
    logic [CHANNELS-1:0] r_vld, n_vld;
    logic                r_rd_vld;
    logic                r_out_valid, n_out_valid;
    t_status             r_status, n_status;
    t_chan               r_chan, n_chan;
    t_word               r_beat, n_beat;
    logic                r_last, n_last;

    logic  out_free;
    logic  in_acc;
    logic  ram_we;
    t_word rd_data;
    logic  stale;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // stamp table
    mchw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CHANNELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_channel[IDX_W-1:0]),
        .i_wdata (i_now),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    // staleness check of the entry just read
    mchw_stale_cmp u_cmp (
        .i_stamp_vld (r_rd_vld),
        .i_stamp     (rd_data),
        .i_now       (r_now),
        .i_timeout   (r_timeout),
        .o_stale     (stale)
    );

    // sequencer and result formation
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_now       = r_now;
        n_count     = r_count;
        n_vld       = r_vld;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_chan      = r_chan;
        n_beat      = r_beat;
        n_last      = r_last;
        ram_we      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_action)
                        ACT_REG: begin
                            n_out_valid = 1'b1;
                            n_beat      = '0;
                            n_last      = 1'b1;
                            if (r_count >= CH_W'(CHANNELS)) begin
                                n_status = ST_FULL;
                                n_chan   = '0;
                            end else begin
                                n_status = ST_REGISTERED;
                                n_chan   = r_count;
                                n_count  = r_count + CH_W'(1);
                            end
                        end
                        ACT_BEAT: begin
                            n_out_valid = 1'b1;
                            n_beat      = '0;
                            n_last      = 1'b1;
                            n_chan      = i_channel;
                            if (i_channel >= CH_W'(CHANNELS)) begin
                                n_status = ST_BAD_CHANNEL;
                            end else begin
                                n_status                       = ST_BEAT;
                                ram_we                         = 1'b1;
                                n_vld[i_channel[IDX_W-1:0]]    = 1'b1;
                            end
                        end
                        ACT_SCAN: begin
                            n_now = i_now;
                            n_idx = '0;
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_status    = ST_DONE;
                                n_chan      = '0;
                                n_beat      = '0;
                                n_last      = 1'b1;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (!stale || out_free) begin
                    if (stale) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_STALE;
                        n_chan      = CH_W'(r_idx);
                        n_beat      = rd_data;
                        n_last      = 1'b0;
                    end
                    if (CH_W'(r_idx) + CH_W'(1) == r_count) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_DONE;
                    n_chan      = '0;
                    n_beat      = '0;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_count     <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            r_timeout   <= TIMEOUT_RST;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_vld       <= n_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_now    <= n_now;
        r_rd_vld <= r_vld[r_idx];
        r_status <= n_status;
        r_chan   <= n_chan;
        r_beat   <= n_beat;
        r_last   <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_channel_res = r_chan;
    assign o_last_beat   = r_beat;
    assign o_last        = r_last;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CH_W'(CHANNELS))
        else $error("registered count beyond table size");

    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_CHK) |-> (CH_W'(r_idx) < r_count))
        else $error("scan index past registered channels");

    a_done_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_DONE) |-> (o_last && o_channel_res == '0))
        else $error("malformed scan done word");

    a_stale_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_STALE) |-> (!o_last && o_last_beat != '0))
        else $error("malformed stale word");

endmodule
`default_nettype wire
